FILE: hw/rtl/mchull_pkg.sv
// Shared types for the convex hull unit: result status codes and the
// command and status bundles between the controller and the datapath.
// No dependencies.
package mchull_pkg;

    // Result status carried in the result tuser field
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_OVER = 2'd2
    } hull_status_t;

    // Controller to datapath commands, one cycle each
    typedef struct packed {
        logic         accept;    // input transfer this cycle
        logic         last;      // transferred point closes the set
        logic         start;     // clear stack and indices for a new build
        logic         load_err;  // load an error result
        hull_status_t err_code;
        logic         rd_pt;     // read point store at j
        logic         j_inc;     // step j by one
        logic         push_q;    // push point store read data
        logic         load_p;    // latch candidate point
        logic         rd_stack;  // read stack at top-2 and top-1
        logic         diff;      // register coordinate differences
        logic         mul;       // register cross products
        logic         pop;       // drop top vertex
        logic         push_p;    // push candidate where the pass allows
        logic         advance;   // next point of the pass
        logic         rd_emit;   // read stack at k
        logic         load_out;  // load a hull vertex result
        logic         next_k;    // step output index
    } hull_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic over;       // set has passed capacity
        logic few;        // fewer than two points held before this one
        logic test_cond;  // stack deep enough for a turn test
        logic turn_neg;   // last turn was strictly clockwise
        logic upper;      // upper pass running
        logic pass_done;  // current point is the last of its pass
        logic emit_last;  // output index at top vertex
    } hull_sts_t;

endpackage

FILE: hw/rtl/mchull_ctrl.sv
// Controller state machine of the convex hull unit: load, lower and upper
// passes, result output. Depends on mchull_pkg.
module mchull_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tlast,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  mchull_pkg::hull_sts_t sts,
    output mchull_pkg::hull_cmd_t cmd
);
    import mchull_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_INIT0,
        S_INIT1,
        S_INIT2,
        S_FETCH,
        S_LOAD,
        S_DIFF,
        S_MUL,
        S_CMP,
        S_POPRD,
        S_PUSH,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    // Command decode and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    cmd.last   = s_tlast;
                    if (s_tlast) begin
                        priority if (sts.over) begin
                            cmd.load_err = 1'b1;
                            cmd.err_code = ST_OVER;
                            state_next   = S_ERR;
                        end else if (sts.few) begin
                            cmd.load_err = 1'b1;
                            cmd.err_code = ST_FEW;
                            state_next   = S_ERR;
                        end else begin
                            cmd.start  = 1'b1;
                            state_next = S_INIT0;
                        end
                    end
                end
            end
            S_ERR: begin
                if (m_tready) state_next = S_IDLE;
            end
            S_INIT0: begin
                cmd.rd_pt  = 1'b1;
                cmd.j_inc  = 1'b1;
                state_next = S_INIT1;
            end
            S_INIT1: begin
                cmd.push_q = 1'b1;
                cmd.rd_pt  = 1'b1;
                cmd.j_inc  = 1'b1;
                state_next = S_INIT2;
            end
            S_INIT2: begin
                cmd.push_q = 1'b1;
                state_next = S_FETCH;
            end
            S_FETCH: begin
                cmd.rd_pt  = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                cmd.load_p   = 1'b1;
                cmd.rd_stack = 1'b1;
                state_next   = sts.test_cond ? S_DIFF : S_PUSH;
            end
            S_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_CMP;
            end
            S_CMP: begin
                if (sts.turn_neg) begin
                    cmd.pop    = 1'b1;
                    state_next = S_POPRD;
                end else begin
                    state_next = S_PUSH;
                end
            end
            S_POPRD: begin
                cmd.rd_stack = 1'b1;
                state_next   = sts.test_cond ? S_DIFF : S_PUSH;
            end
            S_PUSH: begin
                cmd.push_p  = 1'b1;
                cmd.advance = 1'b1;
                state_next  = (sts.upper && sts.pass_done) ? S_EMIT_RD : S_FETCH;
            end
            S_EMIT_RD: begin
                cmd.rd_emit = 1'b1;
                state_next  = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                cmd.load_out = 1'b1;
                state_next   = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (m_tready) begin
                    if (sts.emit_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.next_k = 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.load_err || cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // A result is only offered in the two waiting states
    a_valid_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (state_reg == S_ERR || state_reg == S_EMIT_WAIT))
        else $error("result valid outside a waiting state");

    // Result valid rises only after an error decision or a vertex load
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_IDLE ||
                                  $past(state_reg) == S_EMIT_LD))
        else $error("result valid raised from an unexpected state");

    // A pop is always followed by a fresh stack read
    a_pop_reread: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP && sts.turn_neg) |=> state_reg == S_POPRD)
        else $error("pop not followed by stack re-read");

endmodule

FILE: hw/rtl/mchull_dpath.sv
// Datapath of the convex hull unit: point store, hull stack, indices,
// orientation test pipeline and result register. Depends on mchull_pkg.
module mchull_dpath #(
    parameter int MAX_POINTS = 33,
    parameter int COORD_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [COORD_BITS-1:0]    in_x,
    input  logic [COORD_BITS-1:0]    in_y,
    input  mchull_pkg::hull_cmd_t    cmd,
    output mchull_pkg::hull_sts_t    sts,
    output logic [COORD_BITS-1:0]    out_x,
    output logic [COORD_BITS-1:0]    out_y,
    output logic                     out_last,
    output mchull_pkg::hull_status_t out_status
);
    import mchull_pkg::*;

    localparam int CB          = COORD_BITS;
    localparam int EW          = 2 * CB;
    localparam int PA_W        = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int STACK_DEPTH = 2 * MAX_POINTS - 2;
    localparam int SA_W        = $clog2(STACK_DEPTH);
    localparam int TOP_W       = $clog2(STACK_DEPTH + 1);
    localparam int PW          = 2 * CB + 2;

    // Memories, entries are {y, x}
    logic [EW-1:0] store_mem [MAX_POINTS];
    logic [EW-1:0] stack_mem [STACK_DEPTH];
    logic [EW-1:0] store_q, stack_q0, stack_q1, p_reg;

    // Control registers
    logic [CNT_W-1:0] count_reg, n_reg;
    logic             overflowed_reg;
    logic [TOP_W-1:0] top_reg, lower_size_reg, k_reg;
    logic [PA_W-1:0]  j_reg;
    logic             upper_reg;

    // Orientation test pipeline
    logic signed [CB:0]   d1x_reg, d1y_reg, d2x_reg, d2y_reg;
    logic signed [CB:0]   d1x_next, d1y_next, d2x_next, d2y_next;
    logic signed [PW-1:0] prod1_reg, prod2_reg;

    logic             full, lower_end, push_ok;
    logic [EW-1:0]    wdata;
    logic [TOP_W-1:0] top_m1, top_m2;
    logic [CNT_W-1:0] n_m1;

    // Status and address logic
    always_comb begin
        full      = (count_reg == CNT_W'(MAX_POINTS));
        top_m1    = top_reg - TOP_W'(1);
        top_m2    = top_reg - TOP_W'(2);
        n_m1      = n_reg - CNT_W'(1);
        lower_end = (CNT_W'(j_reg) == n_m1);
        push_ok   = cmd.push_q || (cmd.push_p && (!upper_reg || j_reg != '0));
        wdata     = cmd.push_q ? store_q : p_reg;

        sts.over      = overflowed_reg || full;
        sts.few       = (count_reg < CNT_W'(2));
        sts.test_cond = upper_reg ? (top_reg > lower_size_reg) : (top_reg >= TOP_W'(2));
        sts.turn_neg  = (prod1_reg < prod2_reg);
        sts.upper     = upper_reg;
        sts.pass_done = upper_reg ? (j_reg == '0) : lower_end;
        sts.emit_last = (k_reg == top_m1);
    end

    // Differences about the second-from-top vertex o, top a, candidate b
    always_comb begin
        d1x_next = {stack_q1[CB-1], stack_q1[CB-1:0]} - {stack_q0[CB-1], stack_q0[CB-1:0]};
        d1y_next = {stack_q1[EW-1], stack_q1[EW-1:CB]} - {stack_q0[EW-1], stack_q0[EW-1:CB]};
        d2x_next = {p_reg[CB-1], p_reg[CB-1:0]} - {stack_q0[CB-1], stack_q0[CB-1:0]};
        d2y_next = {p_reg[EW-1], p_reg[EW-1:CB]} - {stack_q0[EW-1], stack_q0[EW-1:CB]};
    end

    // Point store: written on load, read at j
    always_ff @(posedge aclk) begin
        if (cmd.accept && !full) begin
            store_mem[count_reg[PA_W-1:0]] <= {in_y, in_x};
        end
        if (cmd.rd_pt) begin
            store_q <= store_mem[j_reg];
        end
    end

    // Hull stack: one write, two registered reads
    always_ff @(posedge aclk) begin
        if (push_ok) begin
            stack_mem[top_reg[SA_W-1:0]] <= wdata;
        end
        if (cmd.rd_stack || cmd.rd_emit) begin
            stack_q0 <= stack_mem[cmd.rd_emit ? k_reg[SA_W-1:0] : top_m2[SA_W-1:0]];
        end
        if (cmd.rd_stack) begin
            stack_q1 <= stack_mem[top_m1[SA_W-1:0]];
        end
    end

    // Test pipeline, candidate and result registers
    always_ff @(posedge aclk) begin
        if (cmd.load_p) p_reg <= store_q;
        if (cmd.diff) begin
            d1x_reg <= d1x_next;
            d1y_reg <= d1y_next;
            d2x_reg <= d2x_next;
            d2y_reg <= d2y_next;
        end
        if (cmd.mul) begin
            prod1_reg <= d1x_reg * d2y_reg;
            prod2_reg <= d1y_reg * d2x_reg;
        end
        if (cmd.load_err) begin
            out_x      <= '0;
            out_y      <= '0;
            out_last   <= 1'b1;
            out_status <= cmd.err_code;
        end else if (cmd.load_out) begin
            out_x      <= stack_q0[CB-1:0];
            out_y      <= stack_q0[EW-1:CB];
            out_last   <= sts.emit_last;
            out_status <= ST_OK;
        end
    end

    // Counts, indices and pass control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            n_reg          <= '0;
            overflowed_reg <= 1'b0;
            top_reg        <= '0;
            lower_size_reg <= '0;
            k_reg          <= '0;
            j_reg          <= '0;
            upper_reg      <= 1'b0;
        end else begin
            if (cmd.accept) begin
                priority if (cmd.last) begin
                    count_reg      <= '0;
                    overflowed_reg <= 1'b0;
                    n_reg          <= count_reg + CNT_W'(1);
                end else if (full) begin
                    overflowed_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end

            priority if (cmd.start) begin
                top_reg <= '0;
            end else if (cmd.pop) begin
                top_reg <= top_m1;
            end else if (push_ok) begin
                top_reg <= top_reg + TOP_W'(1);
            end

            priority if (cmd.start) begin
                j_reg     <= '0;
                upper_reg <= 1'b0;
            end else if (cmd.j_inc) begin
                j_reg <= j_reg + PA_W'(1);
            end else if (cmd.advance) begin
                if (!upper_reg) begin
                    if (lower_end) begin
                        upper_reg      <= 1'b1;
                        lower_size_reg <= top_reg + TOP_W'(1);
                        j_reg          <= PA_W'(n_reg - CNT_W'(2));
                    end else begin
                        j_reg <= j_reg + PA_W'(1);
                    end
                end else if (j_reg != '0) begin
                    j_reg <= j_reg - PA_W'(1);
                end
            end

            if (cmd.start) begin
                k_reg <= '0;
            end else if (cmd.next_k) begin
                k_reg <= k_reg + TOP_W'(1);
            end
        end
    end

    // Stack never grows past its depth
    a_top_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg <= TOP_W'(STACK_DEPTH))
        else $error("hull stack overrun");

    // Upper pass never pops into the lower hull
    a_upper_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        upper_reg |-> top_reg >= lower_size_reg)
        else $error("upper pass popped into lower hull");

    // A pop only happens with two vertices on the stack
    a_pop_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> top_reg >= TOP_W'(2))
        else $error("pop with fewer than two vertices");

    // Point count stays within capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

endmodule

FILE: hw/rtl/monotone_chain_convex_hull_unit.sv
// Top level of the convex hull unit: stream ports, controller and datapath.
// Depends on mchull_pkg, mchull_ctrl and mchull_dpath.
//
// Convex hull by the monotone chain method. Points of one set arrive one per
// transfer, sorted by x, the last point marked by s_tlast; up to MAX_POINTS
// points are held, one transfer per cycle while loading. After the last point
// the unit builds the lower hull left to right and the upper hull right to
// left, keeping collinear points, then sends the vertices in order with
// m_tlast on the last one and status ok in m_tuser. A set of fewer than three
// points, or of more than MAX_POINTS, gives one result with zero coordinates,
// m_tlast set and the error status. The build opens with init states that
// push the first two points. Each point of each pass then goes through a
// store read, a stack read and a push, with an orientation test (subtract,
// multiply, compare) before the push where the stack is deep enough, and a
// further test (stack re-read, subtract, multiply, compare) after each pop.
// The test is the limiting loop. Each result vertex then passes through a
// stack read, a result load and a wait that holds through any stall on the
// result side. No input is taken while a hull is being built or sent.
// Reset needs no clearing pass.
module monotone_chain_convex_hull_unit #(
    parameter int MAX_POINTS = 33,
    parameter int COORD_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // s_tdata: px, py (from bit 0 up), zero padded to bytes
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    input  logic                                  s_tlast,   // final_point
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // m_tdata: hull_x, hull_y (from bit 0 up), zero padded to bytes
    output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
    output logic [1:0]                            m_tuser,   // status
    output logic                                  m_tlast,   // end_of_hull
    output logic                                  m_tvalid,
    input  logic                                  m_tready
);
    import mchull_pkg::*;

    localparam int DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

    hull_cmd_t               cmd;
    hull_sts_t               sts;
    logic [COORD_BITS-1:0]   out_x, out_y;
    hull_status_t            out_status;

    mchull_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mchull_dpath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_x       (s_tdata[COORD_BITS-1:0]),
        .in_y       (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .cmd        (cmd),
        .sts        (sts),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_last   (m_tlast),
        .out_status (out_status)
    );

    // Result packing
    assign m_tdata = DATA_W'({out_y, out_x});
    assign m_tuser = out_status;

endmodule

FILE: test/tb_monotone_chain_convex_hull_unit.sv
// Self-checking testbench for monotone_chain_convex_hull_unit: point sets go
// in over the input stream, hull vertices are checked against a local model.
// Depends on mchull_pkg and the unit under test.
module tb_monotone_chain_convex_hull_unit;
    import mchull_pkg::*;

    localparam int MAX_PTS   = 33;
    localparam int CRD_BITS  = 16;
    localparam int STK_DEPTH = 64;
    localparam int TD_BITS   = ((2*CRD_BITS+7)/8)*8;

    typedef struct {
        logic signed [CRD_BITS-1:0] x;
        logic signed [CRD_BITS-1:0] y;
    } hull_pt_t;

    typedef struct {
        logic signed [CRD_BITS-1:0] hx;
        logic signed [CRD_BITS-1:0] hy;
        logic                       eoh;
        hull_status_t               st;
    } hull_vtx_t;

    // one directed transfer; st is only meaningful where typed is set
    typedef struct {
        int           x;
        int           y;
        bit           last;
        bit           typed;
        hull_status_t st;
    } dir_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic [TD_BITS-1:0]  s_tdata;   // px, py (from bit 0 up)
    logic                s_tlast;   // final_point
    logic                s_tvalid;
    logic                s_tready;
    logic [TD_BITS-1:0]  m_tdata;   // hull_x, hull_y (from bit 0 up)
    logic [1:0]          m_tuser;   // status
    logic                m_tlast;   // end_of_hull
    logic                m_tvalid;
    logic                m_tready = 1'b0;

    // set being collected by the model
    hull_pt_t    set_pts [MAX_PTS];
    int          set_count = 0;
    bit          set_over  = 0;

    hull_vtx_t   hull_expect_q [$];
    int          hull_err_cnt = 0;
    bit          steady = 0;   // no idling on either side while set

    dir_row_t dir_rows [22] = '{
        // single point: too few
        '{0, 0, 1, 1, ST_FEW},
        // two points at the extremes: too few
        '{-32768, 32767, 0, 0, ST_OK},
        '{32767, -32768, 1, 1, ST_FEW},
        // triangle spanning the full coordinate range
        '{-32768, -32768, 0, 0, ST_OK},
        '{0, 32767, 0, 0, ST_OK},
        '{32767, -32768, 1, 0, ST_OK},
        // box with shared x values and a collinear bottom point
        '{-100, -100, 0, 0, ST_OK},
        '{-100, 100, 0, 0, ST_OK},
        '{0, -100, 0, 0, ST_OK},
        '{100, -100, 0, 0, ST_OK},
        '{100, 100, 1, 0, ST_OK},
        // all on one line
        '{1, 1, 0, 0, ST_OK},
        '{2, 2, 0, 0, ST_OK},
        '{3, 3, 0, 0, ST_OK},
        '{4, 4, 1, 0, ST_OK},
        // all the same point
        '{7, -7, 0, 0, ST_OK},
        '{7, -7, 0, 0, ST_OK},
        '{7, -7, 1, 0, ST_OK},
        // out of x order
        '{500, 0, 0, 0, ST_OK},
        '{-500, 300, 0, 0, ST_OK},
        '{0, -300, 0, 0, ST_OK},
        '{200, 200, 1, 0, ST_OK}
    };

    monotone_chain_convex_hull_unit #(
        .MAX_POINTS(MAX_PTS),
        .COORD_BITS(CRD_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    always #1 aclk = ~aclk;

    // orientation of o->a->b; negative means a clockwise turn
    function automatic logic signed [35:0] turn_of(hull_pt_t o, hull_pt_t a, hull_pt_t b);
        logic signed [35:0] ax, ay, bx, by;
        ax = 36'(a.x) - 36'(o.x);
        ay = 36'(a.y) - 36'(o.y);
        bx = 36'(b.x) - 36'(o.x);
        by = 36'(b.y) - 36'(o.y);
        return ax * by - ay * bx;
    endfunction

    // take one point into the set; on the last point build the hull
    function automatic void predict_hull(input hull_pt_t p, input bit last,
                                         output hull_vtx_t res [$]);
        hull_pt_t stk [STK_DEPTH];
        hull_pt_t q;
        int       n, top, lower, i, k;
        res = {};
        if (set_count < MAX_PTS) begin
            set_pts[set_count] = p;
            set_count++;
        end else begin
            set_over = 1;
        end
        if (!last)
            return;
        n = set_count;
        set_count = 0;
        if (set_over) begin
            set_over = 0;
            res.push_back('{hx: '0, hy: '0, eoh: 1'b1, st: ST_OVER});
            return;
        end
        if (n < 3) begin
            res.push_back('{hx: '0, hy: '0, eoh: 1'b1, st: ST_FEW});
            return;
        end
        // lower chain, left to right
        stk[0] = set_pts[0];
        stk[1] = set_pts[1];
        top = 2;
        for (i = 2; i < n; i++) begin
            while (top >= 2 && turn_of(stk[top-2], stk[top-1], set_pts[i]) < 0)
                top--;
            if (top < STK_DEPTH) begin
                stk[top] = set_pts[i];
                top++;
            end
        end
        lower = top;
        // upper chain, right to left; never pops into the lower chain and
        // does not push the first point a second time
        for (i = n - 1; i > 0; i--) begin
            q = set_pts[i-1];
            while (top > lower && turn_of(stk[top-2], stk[top-1], q) < 0)
                top--;
            if (i > 1 && top < STK_DEPTH) begin
                stk[top] = q;
                top++;
            end
        end
        for (k = 0; k < top; k++)
            res.push_back('{hx: stk[k].x, hy: stk[k].y, eoh: (k == top - 1), st: ST_OK});
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
        hull_err_cnt++;
    endtask

    // offer one point and wait for its transfer
    task automatic offer_point(input hull_pt_t p, input bit last, input bit typed,
                               input hull_status_t st);
        hull_vtx_t res [$];
        while (!steady && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {p.y, p.x};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_hull(p, last, res);
        if (typed)
            hull_expect_q.push_back('{hx: '0, hy: '0, eoh: 1'b1, st: st});
        else
            foreach (res[i]) hull_expect_q.push_back(res[i]);
    endtask

    // hold the input off until every hull vertex is out
    task automatic wait_drained();
        @(posedge aclk);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (hull_expect_q.size() != 0);
    endtask

    // random set: narrow coordinates give many ties and collinear runs
    task automatic send_random_set(input int n, input bit sorted, input bit narrow);
        int       xs [$];
        hull_pt_t p;
        int       i;
        for (i = 0; i < n; i++)
            xs.push_back(narrow ? int'($urandom_range(15)) - 8
                                : int'($urandom_range(65535)) - 32768);
        if (sorted)
            xs.sort();
        for (i = 0; i < n; i++) begin
            p.x = CRD_BITS'(xs[i]);
            p.y = CRD_BITS'(narrow ? int'($urandom_range(15)) - 8
                                   : int'($urandom_range(65535)) - 32768);
            offer_point(p, i == n - 1, 1'b0, ST_OK);
        end
    endtask

    // result side ready, stalling at random outside steady stretches
    always @(posedge aclk)
        m_tready <= steady || ($urandom_range(99) >= 34);

    // compare each result transfer with the oldest expected vertex
    always @(posedge aclk) begin : watch_results
        hull_vtx_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (hull_expect_q.size() == 0) begin
                note_mismatch("unexpected result, hull_x", int'($signed(m_tdata[15:0])), 0);
            end else begin
                e = hull_expect_q.pop_front();
                if (m_tdata[15:0] !== e.hx)
                    note_mismatch("hull_x", int'($signed(m_tdata[15:0])), int'(e.hx));
                if (m_tdata[31:16] !== e.hy)
                    note_mismatch("hull_y", int'($signed(m_tdata[31:16])), int'(e.hy));
                if (m_tlast !== e.eoh)
                    note_mismatch("end_of_hull", int'(m_tlast), int'(e.eoh));
                if (m_tuser !== e.st)
                    note_mismatch("status", int'(m_tuser), int'(e.st));
            end
        end
    end

    // stimulus and end of run
    initial begin
        hull_pt_t p;
        int       sent, set_no, n, r, k;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        s_tdata  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed sets
        foreach (dir_rows[i]) begin
            p.x = CRD_BITS'(dir_rows[i].x);
            p.y = CRD_BITS'(dir_rows[i].y);
            offer_point(p, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].st);
        end
        wait_drained();

        // random sets, mostly sorted
        sent = 0;
        set_no = 0;
        while (sent < 240) begin
            steady = (set_no >= 8 && set_no < 14);
            if (set_no == 12)
                wait_drained();
            if (set_no == 2) begin
                // full set on one line: largest number of vertices
                for (k = 0; k < MAX_PTS; k++) begin
                    p.x = CRD_BITS'(k * 1000 - 16000);
                    p.y = CRD_BITS'(8000 - k * 500);
                    offer_point(p, k == MAX_PTS - 1, 1'b0, ST_OK);
                end
                n = MAX_PTS;
            end else if (set_no == 5) begin
                // one point past capacity
                n = MAX_PTS + 1;
                send_random_set(n, 1'b1, 1'b0);
            end else begin
                r = $urandom_range(99);
                if (r < 10) begin
                    n = $urandom_range(10, 1);
                    send_random_set(n, 1'b0, $urandom_range(1) == 1);
                end else if (r < 18) begin
                    n = $urandom_range(2, 1);
                    send_random_set(n, 1'b1, 1'b0);
                end else if (r < 24) begin
                    n = $urandom_range(MAX_PTS + 4, 13);
                    send_random_set(n, 1'b1, $urandom_range(3) == 0);
                end else begin
                    n = $urandom_range(12, 3);
                    send_random_set(n, 1'b1, $urandom_range(3) == 0);
                end
            end
            sent += n;
            set_no++;
        end
        steady = 0;

        @(posedge aclk);
        s_tvalid <= 1'b0;
        while (hull_expect_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (hull_err_cnt == 0 && hull_expect_q.size() == 0)
            $display("tb_monotone_chain_convex_hull_unit passed");
        else
            $display("tb_monotone_chain_convex_hull_unit failed");
        $finish;
    end

    // run limit
    initial begin
        #1000000;
        $display("tb_monotone_chain_convex_hull_unit failed");
        $finish;
    end

endmodule
